// ===== rtl/core/text_console_cursor_assert.svh =====
// ----------------------------------------------------------------------------
// text_console_cursor_assert.svh
// Assertion macros used by the console cursor checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ASSERT_SVH

// Check a property on every rising clock edge, reset included.
`define TCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// Check a property on every rising clock edge outside reset.
`define TCC_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

// ===== rtl/core/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

    // Operation codes of an input request
    localparam logic [1:0] FUNC_PUT  = 2'd0;
    localparam logic [1:0] FUNC_LINE = 2'd1;
    localparam logic [1:0] FUNC_SET  = 2'd2;

    localparam logic [7:0] CH_NEWLINE = 8'd10;

    // Result kinds
    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_COLUMNS      = 3'd0,
        REG_ROWS         = 3'd1,
        REG_GLYPH_WIDTH  = 3'd2,
        REG_GLYPH_HEIGHT = 3'd3,
        REG_DEFAULT_FG   = 3'd4,
        REG_DEFAULT_BG   = 3'd5
    } t_reg_idx;

    localparam int unsigned ADDR_W = 5;

    // Register reset values
    localparam logic [7:0]  RST_COLUMNS      = 8'd80;
    localparam logic [7:0]  RST_ROWS         = 8'd25;
    localparam logic [5:0]  RST_GLYPH_WIDTH  = 6'd8;
    localparam logic [5:0]  RST_GLYPH_HEIGHT = 6'd16;
    localparam logic [23:0] RST_DEFAULT_FG   = 24'hFFFFFF;
    localparam logic [23:0] RST_DEFAULT_BG   = 24'h000000;

    typedef struct packed {
        logic [7:0]  columns;
        logic [7:0]  rows;
        logic [5:0]  glyph_width;
        logic [5:0]  glyph_height;
        logic [23:0] default_fg;
        logic [23:0] default_bg;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  code;
        logic [23:0] fg;
        logic [23:0] bg;
        logic        use_default;
        logic [7:0]  new_col;
        logic [7:0]  new_row;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  glyph;
        logic [23:0] ink;
        logic [23:0] paper;
        logic [12:0] pixel_x;
        logic [12:0] pixel_y;
        logic        last;
    } t_out_item;

    // Results of one request, handed to the output buffer
    typedef struct packed {
        logic        push;
        logic [1:0]  count;
        t_out_item   first;
        t_out_item   second;
    } t_push;

endpackage

// ===== rtl/core/tcc_in_if.sv =====
// ----------------------------------------------------------------------------
// tcc_in_if
// Valid/ready channel carrying console operation requests.
// ----------------------------------------------------------------------------
interface tcc_in_if;
    logic               valid;
    logic               ready;
    tcc_pkg::t_in_item  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/core/tcc_out_if.sv =====
// ----------------------------------------------------------------------------
// tcc_out_if
// Valid/ready channel carrying draw and scroll commands.
// ----------------------------------------------------------------------------
interface tcc_out_if;
    logic               valid;
    logic               ready;
    tcc_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/core/tcc_regs.sv =====
// ----------------------------------------------------------------------------
// tcc_regs
// APB register file: grid size, glyph size and default colours.
// ----------------------------------------------------------------------------
module tcc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output tcc_pkg::t_cfg                o_cfg
);

    tcc_pkg::t_cfg     r_cfg;
    tcc_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign w_idx  = tcc_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns      <= tcc_pkg::RST_COLUMNS;
            r_cfg.rows         <= tcc_pkg::RST_ROWS;
            r_cfg.glyph_width  <= tcc_pkg::RST_GLYPH_WIDTH;
            r_cfg.glyph_height <= tcc_pkg::RST_GLYPH_HEIGHT;
            r_cfg.default_fg   <= tcc_pkg::RST_DEFAULT_FG;
            r_cfg.default_bg   <= tcc_pkg::RST_DEFAULT_BG;
        end else if (w_wr) begin
            case (w_idx)
                tcc_pkg::REG_COLUMNS:      r_cfg.columns      <= pwdata[7:0];
                tcc_pkg::REG_ROWS:         r_cfg.rows         <= pwdata[7:0];
                tcc_pkg::REG_GLYPH_WIDTH:  r_cfg.glyph_width  <= pwdata[5:0];
                tcc_pkg::REG_GLYPH_HEIGHT: r_cfg.glyph_height <= pwdata[5:0];
                tcc_pkg::REG_DEFAULT_FG:   r_cfg.default_fg   <= pwdata[23:0];
                tcc_pkg::REG_DEFAULT_BG:   r_cfg.default_bg   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (w_idx)
            tcc_pkg::REG_COLUMNS:      prdata = {24'd0, r_cfg.columns};
            tcc_pkg::REG_ROWS:         prdata = {24'd0, r_cfg.rows};
            tcc_pkg::REG_GLYPH_WIDTH:  prdata = {26'd0, r_cfg.glyph_width};
            tcc_pkg::REG_GLYPH_HEIGHT: prdata = {26'd0, r_cfg.glyph_height};
            tcc_pkg::REG_DEFAULT_FG:   prdata = {8'd0, r_cfg.default_fg};
            tcc_pkg::REG_DEFAULT_BG:   prdata = {8'd0, r_cfg.default_bg};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/core/tcc_step.sv =====
// ----------------------------------------------------------------------------
// tcc_step
// Request register, cursor state and the single-pass cursor update that
// builds the scroll and draw results of one request.
// ----------------------------------------------------------------------------
module tcc_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcc_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    input  tcc_pkg::t_in_item   i_item,
    output logic                o_ready,
    input  logic                i_room,
    output tcc_pkg::t_push      o_push
);

    logic              r_valid;
    tcc_pkg::t_in_item r_item;
    logic [7:0]        r_col;
    logic [7:0]        r_row;

    logic [7:0]  n_col;
    logic [7:0]  n_row;
    logic        w_adv;
    logic        w_is_put;
    logic        w_is_nl;
    logic        w_wrap;
    logic        w_scroll;
    logic        w_draw;
    logic [8:0]  w_col_inc;
    logic [8:0]  w_row_inc;
    logic [7:0]  w_row_next;
    logic [7:0]  w_col_draw;
    logic [7:0]  w_row_draw;
    logic [13:0] w_px;
    logic [13:0] w_py;
    logic [23:0] w_ink;
    logic [23:0] w_paper;
    logic [1:0]  w_count;
    tcc_pkg::t_out_item w_scroll_item;
    tcc_pkg::t_out_item w_draw_item;

    // Decode the held request against the current cursor
    always_comb begin
        w_is_put   = (r_item.func == tcc_pkg::FUNC_PUT);
        w_is_nl    = w_is_put && (r_item.code == tcc_pkg::CH_NEWLINE);
        w_col_inc  = {1'b0, r_col} + 9'd1;
        w_row_inc  = {1'b0, r_row} + 9'd1;
        w_wrap     = (r_item.func == tcc_pkg::FUNC_LINE) || w_is_nl
                     || (w_is_put && (w_col_inc >= {1'b0, i_cfg.columns}));
        w_scroll   = w_wrap && (w_row_inc >= {1'b0, i_cfg.rows});
        w_row_next = w_scroll ? r_row : w_row_inc[7:0];
        w_col_draw = w_wrap ? 8'd0 : r_col;
        w_row_draw = w_wrap ? w_row_next : r_row;
        w_draw     = w_is_put && !w_is_nl
                     && (w_col_draw < i_cfg.columns) && (w_row_draw < i_cfg.rows);
        w_px       = {6'd0, w_col_draw} * {8'd0, i_cfg.glyph_width};
        w_py       = {6'd0, w_row_draw} * {8'd0, i_cfg.glyph_height};
        w_ink      = r_item.use_default ? i_cfg.default_fg : r_item.fg;
        w_paper    = r_item.use_default ? i_cfg.default_bg : r_item.bg;
        w_count    = {1'b0, w_scroll} + {1'b0, w_draw};
    end

    // Build the two candidate results
    always_comb begin
        w_scroll_item         = '0;
        w_scroll_item.kind    = tcc_pkg::KIND_SCROLL;
        w_scroll_item.last    = !w_draw;

        w_draw_item.kind      = tcc_pkg::KIND_DRAW;
        w_draw_item.glyph     = r_item.code;
        w_draw_item.ink       = w_ink;
        w_draw_item.paper     = w_paper;
        w_draw_item.pixel_x   = w_px[12:0];
        w_draw_item.pixel_y   = w_py[12:0];
        w_draw_item.last      = 1'b1;
    end

    // Advance when the results fit in the output buffer
    assign w_adv         = r_valid && ((w_count == 2'd0) || i_room);
    assign o_ready       = !r_valid || w_adv;
    assign o_push.push   = w_adv && (w_count != 2'd0);
    assign o_push.count  = w_count;
    assign o_push.first  = w_scroll ? w_scroll_item : w_draw_item;
    assign o_push.second = w_draw_item;

    // Next cursor position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        case (r_item.func)
            tcc_pkg::FUNC_PUT: begin
                if (w_is_nl) begin
                    n_col = 8'd0;
                    n_row = w_row_next;
                end else begin
                    n_col = w_col_draw + 8'd1;
                    n_row = w_row_draw;
                end
            end
            tcc_pkg::FUNC_LINE: begin
                n_col = 8'd0;
                n_row = w_row_next;
            end
            tcc_pkg::FUNC_SET: begin
                n_col = r_item.new_col;
                n_row = r_item.new_row;
            end
            default: ;
        endcase
    end

    // Hold the request and update the cursor as it retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_col   <= 8'd0;
            r_row   <= 8'd0;
        end else begin
            if (w_adv) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/core/tcc_outbuf.sv =====
// ----------------------------------------------------------------------------
// tcc_outbuf
// Two-slot result buffer that presents scroll and draw commands in order.
// ----------------------------------------------------------------------------
module tcc_outbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcc_pkg::t_push      i_push,
    output logic                o_room,
    output logic                o_valid,
    output tcc_pkg::t_out_item  o_item,
    input  logic                i_ready
);

    logic [1:0]         r_cnt;
    tcc_pkg::t_out_item r_slot0;
    tcc_pkg::t_out_item r_slot1;
    logic               w_pop;

    assign w_pop   = (r_cnt != 2'd0) && i_ready;
    assign o_room  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_pop);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot0;

    // Track the fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push.push) begin
            r_cnt <= i_push.count;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Load a new pair or shift the second slot forward
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_slot0 <= i_push.first;
            r_slot1 <= i_push.second;
        end else if (w_pop) begin
            r_slot0 <= r_slot1;
        end
    end

endmodule

// ===== rtl/core/text_console_cursor.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor
// Character-cell console cursor engine: turns put, end-line and set-cursor
// requests into draw commands at pixel positions and scroll-up commands.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Carries
//  i_in     in   valid/ready        func, code, fg, bg, use_default, new_col/row
//  o_out    out  valid/ready        kind, glyph, ink, paper, pixel_x/y, last
//  APB      in   psel/penable/pready 32-bit register writes and reads
//
//  A request is registered, decoded against the cursor in one pass and its
//  zero to two results are registered into a two-slot output buffer once
//  that has room. One result per cycle leaves the buffer while o_out is
//  ready, and a request can retire as the last result before it leaves.
//  Reset is synchronous: cursor at column 0, row 0, buffer empty.
//  A stall on o_out fills the buffer and then holds off i_in.
// ----------------------------------------------------------------------------
module text_console_cursor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tcc_in_if.sink                      i_in,
    tcc_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    tcc_pkg::t_cfg  w_cfg;
    tcc_pkg::t_push w_push;
    logic           w_room;

    tcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tcc_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_in.valid),
        .i_item  (i_in.item),
        .o_ready (i_in.ready),
        .i_room  (w_room),
        .o_push  (w_push)
    );

    tcc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_out.valid),
        .o_item  (o_out.item),
        .i_ready (o_out.ready)
    );

endmodule

// ===== rtl/core/tcc_checker.sv =====
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks on the console cursor engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_cursor_assert.svh"

module tcc_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcc_in_if.sink     i_in,
    tcc_out_if.source  o_out,
    input  logic       pready
);

    // Hold a stalled result
    `TCC_ASSERT_RUN(a_out_hold, o_out.valid && !o_out.ready |=> o_out.valid, "result dropped while stalled")

    // Scroll commands carry no glyph, colour or position
    `TCC_ASSERT_RUN(a_scroll_zero, o_out.valid && o_out.item.kind == tcc_pkg::KIND_SCROLL |-> o_out.item.glyph == 8'd0 && o_out.item.ink == 24'd0 && o_out.item.paper == 24'd0 && o_out.item.pixel_x == 13'd0 && o_out.item.pixel_y == 13'd0, "scroll with payload")

    // A draw always closes its request
    `TCC_ASSERT_RUN(a_draw_last, o_out.valid && o_out.item.kind == tcc_pkg::KIND_DRAW |-> o_out.item.last, "draw not marked last")

    // Reset empties the result buffer and the request register
    `TCC_ASSERT(a_reset_empty, !i_rst_n |=> !o_out.valid && i_in.ready, "not empty after reset")

    // The register port never waits
    `TCC_ASSERT(a_pready, pready, "pready low")

endmodule

bind text_console_cursor tcc_checker u_tcc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out),
    .pready  (pready)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console cursor engine. Requests go in
// through a bursty sender, and the draw and scroll commands they cause are
// predicted from a cursor and register model kept here. Each command taken
// from the output channel is compared field by field with the oldest
// prediction. The register map is swept over several grid and glyph sizes,
// the extremes among them, while in most passes the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcc_pkg::*;

    // Operation code the block leaves unused
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // Cycles with no transfer anywhere before the run is declared hung
    localparam int unsigned STALL_LIMIT = 5000;
    // Cycles to let a request with no result clear the pipeline
    localparam int unsigned PIPE_SETTLE = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    tcc_in_if  req_if ();
    tcc_out_if cmd_if ();

    text_console_cursor DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (cmd_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Model of the registers and the cursor
    t_cfg        model_cfg = '{RST_COLUMNS, RST_ROWS, RST_GLYPH_WIDTH, RST_GLYPH_HEIGHT,
                               RST_DEFAULT_FG, RST_DEFAULT_BG};
    logic [7:0]  model_col = '0;
    logic [7:0]  model_row = '0;

    t_out_item   step_cmds[$];
    t_out_item   expected_cmds[$];
    int unsigned mismatch_cnt = 0;

    // Sender and receiver pacing
    bit          gaps_on = 1'b0;
    int unsigned burst_left = 0;
    bit          stall_on = 1'b0;
    int unsigned hold_req = 0;

    // Clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Move to column zero of the next row; scroll when past the bottom
    function automatic void advance_row();
        logic [8:0] r;
        t_out_item  s;
        r = {1'b0, model_row} + 9'd1;
        model_col = '0;
        if (r >= {1'b0, model_cfg.rows}) begin
            s = '0;
            s.kind = KIND_SCROLL;
            step_cmds.push_back(s);
            r = r - 9'd1;
        end
        model_row = r[7:0];
    endfunction

    function automatic void predict_commands(t_in_item it);
        t_out_item  d;
        logic [13:0] px;
        logic [13:0] py;
        step_cmds.delete();
        case (it.func)
            FUNC_PUT: begin
                if (it.code == CH_NEWLINE) begin
                    advance_row();
                end else begin
                    if ({1'b0, model_col} + 9'd1 >= {1'b0, model_cfg.columns})
                        advance_row();
                    if (model_col < model_cfg.columns && model_row < model_cfg.rows) begin
                        px = {6'd0, model_col} * {8'd0, model_cfg.glyph_width};
                        py = {6'd0, model_row} * {8'd0, model_cfg.glyph_height};
                        d = '0;
                        d.kind    = KIND_DRAW;
                        d.glyph   = it.code;
                        d.ink     = it.use_default ? model_cfg.default_fg : it.fg;
                        d.paper   = it.use_default ? model_cfg.default_bg : it.bg;
                        d.pixel_x = px[12:0];
                        d.pixel_y = py[12:0];
                        step_cmds.push_back(d);
                    end
                    model_col = model_col + 8'd1;
                end
            end
            FUNC_LINE: begin
                advance_row();
            end
            FUNC_SET: begin
                model_col = it.new_col;
                model_row = it.new_row;
            end
            default: begin
            end
        endcase
        if (step_cmds.size() > 0)
            step_cmds[step_cmds.size() - 1].last = 1'b1;
        foreach (step_cmds[i])
            expected_cmds.push_back(step_cmds[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Request sender
    // ------------------------------------------------------------------------

    // Offer one request, hold it until taken, then predict its commands
    task automatic send_request(t_in_item it);
        if (gaps_on) begin
            if (burst_left == 0) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge i_clk);
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
        end
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.item  <= it;
        do @(posedge i_clk); while (!req_if.ready);
        predict_commands(it);
    endtask

    // Drop valid and wait for every predicted command, plus a settle time
    task automatic drain(int unsigned extra);
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // Two-phase register write, mirrored into the model
    task automatic apb_write(t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_COLUMNS:      model_cfg.columns      = val[7:0];
            REG_ROWS:         model_cfg.rows         = val[7:0];
            REG_GLYPH_WIDTH:  model_cfg.glyph_width  = val[5:0];
            REG_GLYPH_HEIGHT: model_cfg.glyph_height = val[5:0];
            REG_DEFAULT_FG:   model_cfg.default_fg   = val[23:0];
            REG_DEFAULT_BG:   model_cfg.default_bg   = val[23:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Load every register once the block is idle
    task automatic load_config(t_cfg c);
        drain(PIPE_SETTLE);
        apb_write(REG_COLUMNS,      {24'd0, c.columns});
        apb_write(REG_ROWS,         {24'd0, c.rows});
        apb_write(REG_GLYPH_WIDTH,  {26'd0, c.glyph_width});
        apb_write(REG_GLYPH_HEIGHT, {26'd0, c.glyph_height});
        apb_write(REG_DEFAULT_FG,   {8'd0, c.default_fg});
        apb_write(REG_DEFAULT_BG,   {8'd0, c.default_bg});
    endtask

    // Cursor coordinate close to a grid edge, or anywhere inside it
    function automatic logic [7:0] near_edge(logic [7:0] limit);
        if ($urandom_range(0, 1) == 0)
            return limit - 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, limit));
    endfunction

    // Mostly character text, some line ends and cursor loads, a little noise
    function automatic t_in_item rand_request();
        t_in_item    it;
        int unsigned w;
        it.code        = 8'($urandom);
        it.fg          = 24'($urandom);
        it.bg          = 24'($urandom);
        it.use_default = 1'($urandom);
        it.new_col     = 8'($urandom);
        it.new_row     = 8'($urandom);
        w = $urandom_range(0, 99);
        if (w < 68) begin
            it.func = FUNC_PUT;
            if ($urandom_range(0, 9) == 0)
                it.code = CH_NEWLINE;
        end else if (w < 78) begin
            it.func = FUNC_LINE;
        end else if (w < 94) begin
            it.func = FUNC_SET;
            if ($urandom_range(0, 4) != 0) begin
                it.new_col = near_edge(model_cfg.columns);
                it.new_row = near_edge(model_cfg.rows);
            end
        end else begin
            it.func = FUNC_UNUSED;
        end
        return it;
    endfunction

    function automatic t_cfg rand_config();
        t_cfg c;
        c.columns      = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                      : 8'($urandom_range(1, 16));
        c.rows         = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                      : 8'($urandom_range(1, 8));
        c.glyph_width  = 6'($urandom_range(1, 32));
        c.glyph_height = 6'($urandom_range(1, 32));
        c.default_fg   = 24'($urandom);
        c.default_bg   = 24'($urandom);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Command receiver and checker
    // ------------------------------------------------------------------------

    initial begin
        int unsigned hold_left;
        int unsigned pat_age;
        int unsigned pat_pos;
        logic [31:0] stall_pat;
        hold_left = 0;
        pat_age   = 0;
        pat_pos   = 0;
        stall_pat = '1;
        cmd_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                cmd_if.ready <= 1'b0;
            end else if (!stall_on) begin
                cmd_if.ready <= 1'b1;
            end else begin
                // Pick a fresh stall pattern now and then, sometimes a clean one
                if (pat_age == 0) begin
                    stall_pat = $urandom;
                    if ($urandom_range(0, 3) == 0)
                        stall_pat = '1;
                    pat_age = $urandom_range(16, 80);
                end
                pat_age--;
                cmd_if.ready <= stall_pat[pat_pos];
                pat_pos = (pat_pos + 1) % 32;
            end
        end
    end

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // Compare each command taken with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            if (expected_cmds.size() == 0) begin
                $error("unexpected command: kind %0d glyph 0x%0h", cmd_if.item.kind,
                       cmd_if.item.glyph);
                mismatch_cnt++;
            end else begin
                want = expected_cmds.pop_front();
                check_field("kind",    24'(want.kind),    24'(cmd_if.item.kind));
                check_field("glyph",   24'(want.glyph),   24'(cmd_if.item.glyph));
                check_field("ink",     want.ink,          cmd_if.item.ink);
                check_field("paper",   want.paper,        cmd_if.item.paper);
                check_field("pixel_x", 24'(want.pixel_x), 24'(cmd_if.item.pixel_x));
                check_field("pixel_y", 24'(want.pixel_y), 24'(cmd_if.item.pixel_y));
                check_field("last",    24'(want.last),    24'(cmd_if.item.last));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        int unsigned idle_cycles;
        if ((req_if.valid && req_if.ready) || (cmd_if.valid && cmd_if.ready) ||
            (psel && penable && pwrite && pready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values, field extremes, wrap, bottom-row scroll, off-grid cursor
    task automatic test_directed();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        send_request('{FUNC_PUT, 8'h00, 24'h000000, 24'h000000, 1'b0, 8'd0, 8'd0});
        send_request('{FUNC_PUT, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 8'd0, 8'd0});
        send_request('{FUNC_PUT, 8'h41, 24'h123456, 24'h654321, 1'b1, 8'd0, 8'd0});
        send_request('{FUNC_PUT, CH_NEWLINE, 24'h0, 24'h0, 1'b0, 8'd0, 8'd0});
        send_request('{FUNC_LINE, 8'h00, 24'h0, 24'h0, 1'b0, 8'd0, 8'd0});
        // Last two columns: draw at the one before last, then wrap
        send_request('{FUNC_SET, 8'h00, 24'h0, 24'h0, 1'b0, 8'd78, 8'd2});
        send_request('{FUNC_PUT, 8'h78, 24'h00FF00, 24'h0000FF, 1'b0, 8'd0, 8'd0});
        send_request('{FUNC_PUT, 8'h79, 24'h00FF00, 24'h0000FF, 1'b0, 8'd0, 8'd0});
        // Newline, wrap and end line on the bottom row all scroll
        send_request('{FUNC_SET, 8'h00, 24'h0, 24'h0, 1'b0, 8'd0, 8'd24});
        send_request('{FUNC_PUT, CH_NEWLINE, 24'h0, 24'h0, 1'b1, 8'd0, 8'd0});
        send_request('{FUNC_SET, 8'h00, 24'h0, 24'h0, 1'b0, 8'd79, 8'd24});
        send_request('{FUNC_PUT, 8'h7A, 24'hFF0000, 24'h00FFFF, 1'b0, 8'd0, 8'd0});
        send_request('{FUNC_LINE, 8'h00, 24'h0, 24'h0, 1'b0, 8'd0, 8'd0});
        // Cursor below the grid: no draw, scroll keeps the row
        send_request('{FUNC_SET, 8'h00, 24'h0, 24'h0, 1'b0, 8'd10, 8'd200});
        send_request('{FUNC_PUT, 8'h71, 24'h111111, 24'h222222, 1'b0, 8'd0, 8'd0});
        send_request('{FUNC_LINE, 8'h00, 24'h0, 24'h0, 1'b0, 8'd0, 8'd0});
        send_request('{FUNC_SET, 8'h00, 24'h0, 24'h0, 1'b0, 8'd255, 8'd255});
        send_request('{FUNC_PUT, 8'h77, 24'h333333, 24'h444444, 1'b0, 8'd0, 8'd0});
        // Unused operation with every field set
        send_request('{FUNC_UNUSED, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 8'hFF, 8'hFF});
        send_request('{FUNC_SET, 8'h00, 24'h0, 24'h0, 1'b0, 8'd0, 8'd0});
        send_request('{FUNC_PUT, 8'h55, 24'hAAAAAA, 24'h555555, 1'b0, 8'hAA, 8'h55});
        send_request('{FUNC_PUT, 8'hAA, 24'h555555, 24'hAAAAAA, 1'b1, 8'h55, 8'hAA});
    endtask

    // Random text over a sweep of register settings, extremes first
    task automatic test_config_sweep();
        t_cfg c;
        for (int p = 0; p < 11; p++) begin
            case (p)
                0: c = '{8'd1, 8'd1, 6'd1, 6'd1, 24'h000000, 24'hFFFFFF};
                1: c = '{8'd255, 8'd255, 6'd32, 6'd32, 24'h0F0F0F, 24'hF0F0F0};
                2: c = '{8'd255, 8'd255, 6'd63, 6'd63, 24'hFFFFFF, 24'h000000};
                3: c = '{8'd0, 8'd0, 6'd8, 6'd16, 24'h5A5A5A, 24'hA5A5A5};
                4: c = '{RST_COLUMNS, RST_ROWS, RST_GLYPH_WIDTH, RST_GLYPH_HEIGHT,
                         RST_DEFAULT_FG, RST_DEFAULT_BG};
                default: c = rand_config();
            endcase
            load_config(c);
            gaps_on  = (p % 3) != 2;
            stall_on = (p % 4) != 3;
            repeat (44) send_request(rand_request());
        end
    endtask

    // Hold the receiver off long enough that the block stalls its input
    task automatic test_backpressure();
        load_config('{8'd6, 8'd3, 6'd5, 6'd7, 24'($urandom), 24'($urandom)});
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        hold_req = 300;
        repeat (40) send_request(rand_request());
    endtask

    // Pause the sender until every predicted command has come out
    task automatic test_drain_pause();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        repeat (15) send_request(rand_request());
        drain(0);
        repeat (15) send_request(rand_request());
    endtask

    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.item  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_config_sweep();
        test_backpressure();
        test_drain_pause();

        drain(PIPE_SETTLE);
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
